// ----- rtl/ec_i2c_slave_transfer_engine_macros.svh -----
// assertion macros for the i2c slave transfer engine checker
// relies on clock and reset being visible where a macro is used
`ifndef EC_I2C_SLAVE_TRANSFER_ENGINE_MACROS_SVH
`define EC_I2C_SLAVE_TRANSFER_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define EC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ec_i2c checker: same-cycle property failed");

// next-cycle implication, disabled during reset
`define EC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ec_i2c checker: next-cycle property failed");

`endif

// ----- rtl/ec_i2c_pkg.sv -----
// shared constants, codes and control structs for the i2c slave transfer engine
// no dependencies
package ec_i2c_pkg;

   // store sizes
   localparam int RX_DEPTH  = 34;
   localparam int TX_DEPTH  = 32;
   localparam int RX_CNT_W  = $clog2(RX_DEPTH + 1);
   localparam int RX_ADDR_W = $clog2(RX_DEPTH);
   localparam int TX_CNT_W  = $clog2(TX_DEPTH + 1);
   localparam int TX_ADDR_W = $clog2(TX_DEPTH);

   // field widths
   localparam int FUNC_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int CODE_W  = 3;
   localparam int PHASE_W = 3;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOOP_FIRST  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOOP_SECOND = 2'd2;
   localparam logic [BYTE_W-1:0]    OWN_ADDRESS_RESET = 8'd138;

   // request functions
   localparam logic [FUNC_W-1:0] FUNC_BEGIN  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_EVENT  = 2'd2;

   // result codes
   localparam logic [CODE_W-1:0] CODE_NONE      = 3'd0;
   localparam logic [CODE_W-1:0] CODE_READ_OK   = 3'd1;
   localparam logic [CODE_W-1:0] CODE_WRITE_OK  = 3'd2;
   localparam logic [CODE_W-1:0] CODE_BAD_ADDR  = 3'd3;
   localparam logic [CODE_W-1:0] CODE_WRONG_CMD = 3'd4;
   localparam logic [CODE_W-1:0] CODE_NO_DATA   = 3'd5;
   localparam logic [CODE_W-1:0] CODE_RETRY     = 3'd6;

   // bus phases
   localparam logic [PHASE_W-1:0] PH_BEGIN  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_CMD    = 3'd1;
   localparam logic [PHASE_W-1:0] PH_SUBCMD = 3'd2;
   localparam logic [PHASE_W-1:0] PH_READ   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_WRITE  = 3'd5;

   localparam logic [BYTE_W-1:0] READ_COMMAND = 8'h01;
   localparam int NOOP_LEN = 2;

   // controller to datapath
   typedef struct packed {
      logic accept;    // capture the input transfer, prefetch tx store
      logic commit;    // apply the step and load its result
      logic noop_wr;   // write second no-op byte
      logic dump_rd;   // read the next message byte
      logic dump_out;  // load a message byte as a result
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic func_none;   // item yields nothing
      logic out_free;    // result register can take a new result
      logic start_dump;  // step ends a message, dump follows
      logic start_noop;  // step loads the no-op request
      logic dump_last;   // current message byte is the final one
   } dp_status_type;

endpackage

// ----- rtl/ec_i2c_ctrl.sv -----
// controller state machine for the i2c slave transfer engine
// depends on ec_i2c_pkg
module ec_i2c_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ec_i2c_pkg::dp_status_type status,
   output ec_i2c_pkg::ctrl_cmd_type  cmd
);
   import ec_i2c_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_EXEC     = 3'd1;
   localparam logic [2:0] ST_NOOP     = 3'd2;
   localparam logic [2:0] ST_DUMP_RD  = 3'd3;
   localparam logic [2:0] ST_DUMP_OUT = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.func_none) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.commit = 1'b1;
               if (status.start_dump) begin
                  state_in = ST_DUMP_RD;
               end else if (status.start_noop) begin
                  state_in = ST_NOOP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_NOOP: begin
            cmd.noop_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_DUMP_RD: begin
            cmd.dump_rd = 1'b1;
            state_in    = ST_DUMP_OUT;
         end
         ST_DUMP_OUT: begin
            if (status.out_free) begin
               cmd.dump_out = 1'b1;
               state_in     = status.dump_last ? ST_IDLE : ST_DUMP_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/ec_i2c_datapath.sv -----
// datapath of the i2c slave transfer engine: registers, stores, step logic, result register
// depends on ec_i2c_pkg, driven by ec_i2c_ctrl
module ec_i2c_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  ec_i2c_pkg::ctrl_cmd_type            cmd,
   output ec_i2c_pkg::dp_status_type           status,
   input  logic                                csr_write,
   input  logic [ec_i2c_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ec_i2c_pkg::BYTE_W-1:0]       csr_wdata,
   input  logic [ec_i2c_pkg::FUNC_W-1:0]       req_func,
   input  logic [ec_i2c_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                                req_read_dir,
   input  logic                                req_start_seen,
   input  logic                                req_end_of_transfer,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [ec_i2c_pkg::CODE_W-1:0]       rsp_code,
   output logic                                rsp_tx_valid,
   output logic [ec_i2c_pkg::BYTE_W-1:0]       rsp_tx_byte,
   output logic                                rsp_request_line,
   output logic                                rsp_msg_valid,
   output logic [ec_i2c_pkg::BYTE_W-1:0]       rsp_msg_byte,
   output logic                                rsp_last,
   output logic                                rsp_rx_overflow
);
   import ec_i2c_pkg::*;

   // configuration
   logic [BYTE_W-1:0] own_addr_ff, noop_first_ff, noop_second_ff;

   // captured item
   logic [FUNC_W-1:0] it_func_ff;
   logic [BYTE_W-1:0] it_data_ff;
   logic              it_rd_ff, it_st_ff, it_end_ff;

   // engine state
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [BYTE_W-1:0]   last_rx_ff, last_rx_in;
   logic [BYTE_W-1:0]   cmd_byte_ff, cmd_byte_in;
   logic [RX_CNT_W-1:0] rx_count_ff, rx_count_in;
   logic [TX_CNT_W-1:0] tx_count_ff, tx_count_in;
   logic [TX_CNT_W-1:0] tx_index_ff, tx_index_in;
   logic                present_ff, present_in;
   logic                level_ff, level_in;
   logic [RX_ADDR_W-1:0] dump_idx_ff, dump_idx_in;

   // stores
   logic [BYTE_W-1:0]    rx_mem [RX_DEPTH];
   logic [BYTE_W-1:0]    tx_mem [TX_DEPTH];
   logic [BYTE_W-1:0]    rx_rd_ff, tx_rd_ff;
   logic                 rx_we, tx_we;
   logic [RX_ADDR_W-1:0] rx_wa;
   logic [TX_ADDR_W-1:0] tx_wa;
   logic [BYTE_W-1:0]    rx_wd, tx_wd;

   // step outcome
   logic [PHASE_W-1:0]  s_phase;
   logic [BYTE_W-1:0]   s_last_rx;
   logic [RX_CNT_W-1:0] s_rx_count;
   logic [TX_CNT_W-1:0] s_tx_count, s_tx_index;
   logic                s_present, s_level;
   logic                s_rx_we, s_tx_we;
   logic [RX_ADDR_W-1:0] s_rx_wa;
   logic [TX_ADDR_W-1:0] s_tx_wa;
   logic [BYTE_W-1:0]   s_rx_wd, s_tx_wd;
   logic                s_emit, s_dump, s_noop;
   logic [CODE_W-1:0]   s_code;
   logic                s_txv, s_ovf;
   logic [BYTE_W-1:0]   s_txb;

   logic [BYTE_W-1:0]   rcv;
   logic                wr_start, rx_full;
   logic [PHASE_W-1:0]  ph;
   logic [RX_CNT_W-1:0] rxc;
   logic [TX_CNT_W-1:0] txi;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]   rsp_code_ff, rsp_code_in;
   logic                rsp_txv_ff, rsp_txv_in;
   logic [BYTE_W-1:0]   rsp_txb_ff, rsp_txb_in;
   logic                rsp_line_ff, rsp_line_in;
   logic                rsp_mv_ff, rsp_mv_in;
   logic [BYTE_W-1:0]   rsp_mb_ff, rsp_mb_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_ovf_ff, rsp_ovf_in;
   logic                out_free, load_step, dump_last;

   // step of one captured item against the current state
   always_comb begin
      rcv      = it_rd_ff ? last_rx_ff : it_data_ff;
      wr_start = it_st_ff && !it_rd_ff && !it_end_ff;
      ph       = wr_start ? PH_BEGIN : phase_ff;
      rxc      = wr_start ? '0 : rx_count_ff;
      txi      = wr_start ? '0 : tx_index_ff;
      rx_full  = (rxc >= RX_CNT_W'(RX_DEPTH));

      s_phase    = phase_ff;
      s_last_rx  = last_rx_ff;
      s_rx_count = rx_count_ff;
      s_tx_count = tx_count_ff;
      s_tx_index = tx_index_ff;
      s_present  = present_ff;
      s_level    = level_ff;
      s_rx_we    = 1'b0;
      s_rx_wa    = rxc[RX_ADDR_W-1:0];
      s_rx_wd    = rcv;
      s_tx_we    = 1'b0;
      s_tx_wa    = tx_count_ff[TX_ADDR_W-1:0];
      s_tx_wd    = it_data_ff;
      s_emit     = 1'b1;
      s_dump     = 1'b0;
      s_noop     = 1'b0;
      s_code     = CODE_NONE;
      s_txv      = 1'b0;
      s_txb      = '0;
      s_ovf      = 1'b0;

      priority if (it_func_ff == FUNC_BEGIN) begin
         s_tx_count = '0;
         s_tx_index = '0;
         s_present  = 1'b1;
         s_level    = 1'b0;
      end else if (it_func_ff == FUNC_APPEND) begin
         if (tx_count_ff < TX_CNT_W'(TX_DEPTH)) begin
            s_tx_we    = 1'b1;
            s_tx_count = tx_count_ff + TX_CNT_W'(1);
         end
      end else if (it_func_ff == FUNC_EVENT) begin
         s_last_rx  = rcv;
         s_phase    = ph;
         s_rx_count = rxc;
         s_tx_index = txi;
         s_code     = it_end_ff ? CODE_RETRY : CODE_NONE;
         unique case (ph)
            PH_BEGIN: begin
               s_rx_count = '0;
               s_tx_index = '0;
               if (rcv != own_addr_ff) begin
                  s_code = CODE_BAD_ADDR;
               end else begin
                  s_phase = PH_CMD;
               end
            end
            PH_CMD: begin
               if (!rx_full) begin
                  s_rx_we    = 1'b1;
                  s_rx_count = rxc + RX_CNT_W'(1);
               end
               s_phase = PH_SUBCMD;
            end
            PH_SUBCMD: begin
               if (it_st_ff && it_rd_ff && !it_end_ff) begin
                  if (cmd_byte_ff != READ_COMMAND) begin
                     s_phase = PH_BEGIN;
                     s_code  = CODE_WRONG_CMD;
                  end else begin
                     s_phase = PH_WRITE;
                     s_txv   = 1'b1;
                     s_txb   = BYTE_W'(tx_count_ff);
                     s_level = 1'b1;
                     if (!present_ff) begin
                        // default request: two bytes, first written now
                        s_tx_count = TX_CNT_W'(NOOP_LEN);
                        s_tx_index = '0;
                        s_present  = 1'b1;
                        s_tx_we    = 1'b1;
                        s_tx_wa    = '0;
                        s_tx_wd    = noop_first_ff;
                        s_noop     = 1'b1;
                        s_txb      = BYTE_W'(NOOP_LEN);
                     end
                  end
               end else begin
                  s_phase = PH_READ;
                  if (!rx_full) begin
                     s_rx_we    = 1'b1;
                     s_rx_count = rxc + RX_CNT_W'(1);
                  end else begin
                     s_ovf = 1'b1;
                  end
               end
            end
            PH_READ: begin
               if (rx_full) begin
                  s_ovf = 1'b1;
               end else begin
                  s_rx_we    = 1'b1;
                  s_rx_count = rxc + RX_CNT_W'(1);
                  if (it_end_ff) begin
                     // count stays until the dump has walked the store
                     s_dump = 1'b1;
                     s_emit = 1'b0;
                  end
               end
            end
            PH_WRITE: begin
               if (txi >= tx_count_ff) begin
                  s_code = it_end_ff ? CODE_WRITE_OK : CODE_NO_DATA;
               end else begin
                  s_txv      = 1'b1;
                  s_txb      = tx_rd_ff;
                  s_tx_index = txi + TX_CNT_W'(1);
                  s_code     = CODE_NONE;
                  if (it_end_ff) begin
                     s_tx_index = '0;
                     s_present  = 1'b0;
                     s_code     = CODE_WRITE_OK;
                  end
               end
            end
            default: begin
            end
         endcase
      end else begin
         s_emit = 1'b0;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign dump_last = ((RX_CNT_W'(dump_idx_ff) + RX_CNT_W'(1)) == rx_count_ff);
   assign load_step = cmd.commit && s_emit;

   assign status.func_none  = (it_func_ff != FUNC_BEGIN) && (it_func_ff != FUNC_APPEND)
                              && (it_func_ff != FUNC_EVENT);
   assign status.out_free   = out_free;
   assign status.start_dump = s_dump;
   assign status.start_noop = s_noop;
   assign status.dump_last  = dump_last;

   // state update and store writes
   always_comb begin
      phase_in    = phase_ff;
      last_rx_in  = last_rx_ff;
      rx_count_in = rx_count_ff;
      tx_count_in = tx_count_ff;
      tx_index_in = tx_index_ff;
      present_in  = present_ff;
      level_in    = level_ff;
      dump_idx_in = dump_idx_ff;
      rx_we       = 1'b0;
      rx_wa       = s_rx_wa;
      rx_wd       = s_rx_wd;
      tx_we       = 1'b0;
      tx_wa       = s_tx_wa;
      tx_wd       = s_tx_wd;
      if (cmd.commit) begin
         phase_in    = s_phase;
         last_rx_in  = s_last_rx;
         rx_count_in = s_rx_count;
         tx_count_in = s_tx_count;
         tx_index_in = s_tx_index;
         present_in  = s_present;
         level_in    = s_level;
         rx_we       = s_rx_we;
         tx_we       = s_tx_we;
         dump_idx_in = '0;
      end
      if (cmd.noop_wr) begin
         tx_we = 1'b1;
         tx_wa = TX_ADDR_W'(1);
         tx_wd = noop_second_ff;
      end
      if (cmd.dump_out) begin
         if (dump_last) begin
            rx_count_in = '0;
            dump_idx_in = '0;
         end else begin
            dump_idx_in = dump_idx_ff + RX_ADDR_W'(1);
         end
      end
      cmd_byte_in = (rx_we && (rx_wa == '0)) ? rx_wd : cmd_byte_ff;
   end

   // result register
   always_comb begin
      rsp_valid_in = (rsp_valid_ff && rsp_stall) || load_step || cmd.dump_out;
      rsp_code_in  = rsp_code_ff;
      rsp_txv_in   = rsp_txv_ff;
      rsp_txb_in   = rsp_txb_ff;
      rsp_line_in  = rsp_line_ff;
      rsp_mv_in    = rsp_mv_ff;
      rsp_mb_in    = rsp_mb_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (load_step) begin
         rsp_code_in = s_code;
         rsp_txv_in  = s_txv;
         rsp_txb_in  = s_txb;
         rsp_line_in = s_level;
         rsp_mv_in   = 1'b0;
         rsp_mb_in   = '0;
         rsp_last_in = 1'b1;
         rsp_ovf_in  = s_ovf;
      end else if (cmd.dump_out) begin
         rsp_code_in = CODE_READ_OK;
         rsp_txv_in  = 1'b0;
         rsp_txb_in  = '0;
         rsp_line_in = level_ff;
         rsp_mv_in   = 1'b1;
         rsp_mb_in   = rx_rd_ff;
         rsp_last_in = dump_last;
         rsp_ovf_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff    <= OWN_ADDRESS_RESET;
         noop_first_ff  <= '0;
         noop_second_ff <= '0;
         phase_ff       <= PH_BEGIN;
         last_rx_ff     <= '0;
         rx_count_ff    <= '0;
         tx_count_ff    <= '0;
         tx_index_ff    <= '0;
         present_ff     <= 1'b0;
         level_ff       <= 1'b1;
         dump_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write && (csr_index == CSR_OWN_ADDRESS)) own_addr_ff    <= csr_wdata;
         if (csr_write && (csr_index == CSR_NOOP_FIRST))  noop_first_ff  <= csr_wdata;
         if (csr_write && (csr_index == CSR_NOOP_SECOND)) noop_second_ff <= csr_wdata;
         phase_ff     <= phase_in;
         last_rx_ff   <= last_rx_in;
         rx_count_ff  <= rx_count_in;
         tx_count_ff  <= tx_count_in;
         tx_index_ff  <= tx_index_in;
         present_ff   <= present_in;
         level_ff     <= level_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         it_func_ff <= req_func;
         it_data_ff <= req_data_byte;
         it_rd_ff   <= req_read_dir;
         it_st_ff   <= req_start_seen;
         it_end_ff  <= req_end_of_transfer;
      end
      cmd_byte_ff <= cmd_byte_in;
      rsp_code_ff <= rsp_code_in;
      rsp_txv_ff  <= rsp_txv_in;
      rsp_txb_ff  <= rsp_txb_in;
      rsp_line_ff <= rsp_line_in;
      rsp_mv_ff   <= rsp_mv_in;
      rsp_mb_ff   <= rsp_mb_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // message store
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_mem[rx_wa] <= rx_wd;
      end
      if (cmd.dump_rd) begin
         rx_rd_ff <= rx_mem[dump_idx_ff];
      end
   end

   // request store, prefetched at the send index when an item comes in
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_mem[tx_wa] <= tx_wd;
      end
      if (cmd.accept && (tx_index_ff < TX_CNT_W'(TX_DEPTH))) begin
         tx_rd_ff <= tx_mem[tx_index_ff[TX_ADDR_W-1:0]];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_code         = rsp_code_ff;
   assign rsp_tx_valid     = rsp_txv_ff;
   assign rsp_tx_byte      = rsp_txb_ff;
   assign rsp_request_line = rsp_line_ff;
   assign rsp_msg_valid    = rsp_mv_ff;
   assign rsp_msg_byte     = rsp_mb_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_rx_overflow  = rsp_ovf_ff;

endmodule

// ----- rtl/ec_i2c_slave_transfer_engine.sv -----
// top level of the i2c slave transfer engine
// depends on ec_i2c_pkg, ec_i2c_ctrl and ec_i2c_datapath
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  func, data_byte, read_dir, start_seen,
//                                               end_of_transfer
//   rsp_      out        rsp_valid / rsp_stall  code, tx_valid, tx_byte, request_line,
//                                               msg_valid, msg_byte, last, rx_overflow
//   csr_      in         csr_write              csr_index, csr_wdata (no read-back)
//
// one item at a time: a capture, then the step, which waits for a free result register
// a no-op read start passes through the no-op state for the second no-op byte store write
// a message stop adds, per stored byte, a message store read and a result load
// rsp_stall holds the step or dump byte in place; the next item is still taken while
// a finished result waits in the result register
// synchronous active-high reset; the stores need no clearing pass
module ec_i2c_slave_transfer_engine (
   input  logic                                clock,
   input  logic                                reset,
   // configuration writes
   input  logic                                csr_write,
   input  logic [ec_i2c_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ec_i2c_pkg::BYTE_W-1:0]       csr_wdata,
   // requests and bus events
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ec_i2c_pkg::FUNC_W-1:0]       req_func,
   input  logic [ec_i2c_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic                                req_read_dir,
   input  logic                                req_start_seen,
   input  logic                                req_end_of_transfer,
   // results
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ec_i2c_pkg::CODE_W-1:0]       rsp_code,
   output logic                                rsp_tx_valid,
   output logic [ec_i2c_pkg::BYTE_W-1:0]       rsp_tx_byte,
   output logic                                rsp_request_line,
   output logic                                rsp_msg_valid,
   output logic [ec_i2c_pkg::BYTE_W-1:0]       rsp_msg_byte,
   output logic                                rsp_last,
   output logic                                rsp_rx_overflow
);
   import ec_i2c_pkg::*;

   // command and status between the sequencer and the datapath
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer: idle, step, no-op second byte, message dump
   ec_i2c_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // bus phase machine, request and message stores, result register
   ec_i2c_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_func            (req_func),
      .req_data_byte       (req_data_byte),
      .req_read_dir        (req_read_dir),
      .req_start_seen      (req_start_seen),
      .req_end_of_transfer (req_end_of_transfer),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_code            (rsp_code),
      .rsp_tx_valid        (rsp_tx_valid),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_request_line    (rsp_request_line),
      .rsp_msg_valid       (rsp_msg_valid),
      .rsp_msg_byte        (rsp_msg_byte),
      .rsp_last            (rsp_last),
      .rsp_rx_overflow     (rsp_rx_overflow)
   );

endmodule

// ----- rtl/ec_i2c_checker.sv -----
// port-level checker for the i2c slave transfer engine, bound to the top level
// depends on ec_i2c_pkg and ec_i2c_slave_transfer_engine_macros.svh
`include "ec_i2c_slave_transfer_engine_macros.svh"

module ec_i2c_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [ec_i2c_pkg::CODE_W-1:0]       rsp_code,
   input logic                                rsp_tx_valid,
   input logic [ec_i2c_pkg::BYTE_W-1:0]       rsp_tx_byte,
   input logic                                rsp_msg_valid,
   input logic [ec_i2c_pkg::BYTE_W-1:0]       rsp_msg_byte,
   input logic                                rsp_last,
   input logic                                rsp_rx_overflow
);
   import ec_i2c_pkg::*;

   logic rsp_held;
   logic msg_shape_ok;
   logic tx_zero_ok;
   logic msg_zero_ok;

   assign rsp_held     = rsp_valid && rsp_stall;
   assign msg_shape_ok = (rsp_code == CODE_READ_OK) && !rsp_tx_valid;
   assign tx_zero_ok   = rsp_tx_valid || (rsp_tx_byte == '0);
   assign msg_zero_ok  = rsp_msg_valid || (rsp_msg_byte == '0);

   // a stalled result transfer holds
   `EC_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable({rsp_code, rsp_msg_byte}))

   // an accepted item keeps the input side closed for its step
   `EC_ASSERT_NEXT(a_one_item, req_valid && !req_stall, req_stall)

   // message bytes come only as read-ok results with no transmit byte
   `EC_ASSERT_IMPL(a_msg_code, rsp_valid && rsp_msg_valid, msg_shape_ok)

   // unused byte fields read as zero
   `EC_ASSERT_IMPL(a_zero_bytes, rsp_valid, tx_zero_ok && msg_zero_ok)

   // a dropped byte is reported on a single final result, never in a message
   `EC_ASSERT_IMPL(a_ovf_last, rsp_valid && rsp_rx_overflow, rsp_last && !rsp_msg_valid)

endmodule

bind ec_i2c_slave_transfer_engine ec_i2c_checker u_checker (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// self-checking bench for ec_i2c_slave_transfer_engine: directed rows, then random bus traffic
// depends on ec_i2c_pkg and the rtl of the engine
module tb;
   import ec_i2c_pkg::*;

   // func code that the engine ignores
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   // cycles with no transfer on either channel before the run is called hung
   localparam int IDLE_LIMIT = 4000;
   // quiet cycles after the last result, covers an ignored item still in flight
   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_CYCLES = 100;
   localparam int ITEM_GOAL = 260;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [BYTE_W-1:0] data;
      logic              read_dir;
      logic              start_seen;
      logic              stop;
   } bus_item_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              tx_valid;
      logic [BYTE_W-1:0] tx_byte;
      logic              request_line;
      logic              msg_valid;
      logic [BYTE_W-1:0] msg_byte;
      logic              last;
      logic              rx_overflow;
   } bus_result_type;

   typedef struct packed {
      bus_item_type   item;
      logic           typed;
      bus_result_type want;
   } directed_row_type;

   // results that can be read straight off the spec
   localparam bus_result_type R_NONE       = '0;
   localparam bus_result_type R_BAD_ADDR   =
      '{CODE_BAD_ADDR, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0};
   localparam bus_result_type R_IDLE_HIGH  =
      '{CODE_NONE, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0};
   localparam bus_result_type R_NOOP_LEN   =
      '{CODE_NONE, 1'b1, 8'h02, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0};
   localparam bus_result_type R_LOADED     =
      '{CODE_NONE, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0};
   localparam bus_result_type R_NO_DATA    =
      '{CODE_NO_DATA, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0};
   localparam bus_result_type R_WRITE_DONE =
      '{CODE_WRITE_OK, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0};
   localparam bus_result_type R_WRONG_CMD  =
      '{CODE_WRONG_CMD, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0};
   localparam bus_result_type R_RETRY      =
      '{CODE_RETRY, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0};

   // directed rows: func, data, read_dir, start_seen, stop / typed / result
   localparam int DIRECTED_LEN = 26;
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_LEN] = '{
      // wrong address right after reset
      '{'{FUNC_EVENT, 8'h00, 1'b0, 1'b1, 1'b0}, 1'b1, R_BAD_ADDR},
      '{'{FUNC_EVENT, OWN_ADDRESS_RESET, 1'b0, 1'b1, 1'b0}, 1'b1, R_IDLE_HIGH},
      '{'{FUNC_EVENT, READ_COMMAND, 1'b0, 1'b0, 1'b0}, 1'b0, R_NONE},
      // read start with nothing queued sends the no-op
      '{'{FUNC_EVENT, 8'hFF, 1'b1, 1'b1, 1'b0}, 1'b1, R_NOOP_LEN},
      '{'{FUNC_EVENT, 8'h00, 1'b1, 1'b0, 1'b0}, 1'b0, R_NONE},
      '{'{FUNC_EVENT, 8'h00, 1'b1, 1'b0, 1'b1}, 1'b0, R_NONE},
      // load a two byte request, line goes low
      '{'{FUNC_BEGIN, 8'h5A, 1'b1, 1'b1, 1'b1}, 1'b1, R_LOADED},
      '{'{FUNC_APPEND, 8'hFF, 1'b0, 1'b0, 1'b0}, 1'b1, R_LOADED},
      '{'{FUNC_APPEND, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, R_NONE},
      // read it back, then run past its end
      '{'{FUNC_EVENT, OWN_ADDRESS_RESET, 1'b0, 1'b1, 1'b0}, 1'b0, R_NONE},
      '{'{FUNC_EVENT, READ_COMMAND, 1'b0, 1'b0, 1'b0}, 1'b0, R_NONE},
      '{'{FUNC_EVENT, 8'h00, 1'b1, 1'b1, 1'b0}, 1'b0, R_NONE},
      '{'{FUNC_EVENT, 8'h00, 1'b1, 1'b0, 1'b0}, 1'b0, R_NONE},
      '{'{FUNC_EVENT, 8'h00, 1'b1, 1'b0, 1'b0}, 1'b0, R_NONE},
      '{'{FUNC_EVENT, 8'h00, 1'b1, 1'b0, 1'b0}, 1'b1, R_NO_DATA},
      '{'{FUNC_EVENT, 8'h00, 1'b1, 1'b0, 1'b1}, 1'b1, R_WRITE_DONE},
      // read start after a command other than read
      '{'{FUNC_EVENT, OWN_ADDRESS_RESET, 1'b0, 1'b1, 1'b0}, 1'b0, R_NONE},
      '{'{FUNC_EVENT, 8'h55, 1'b0, 1'b0, 1'b0}, 1'b0, R_NONE},
      '{'{FUNC_EVENT, 8'h00, 1'b1, 1'b1, 1'b0}, 1'b1, R_WRONG_CMD},
      // short message, dumped at the stop
      '{'{FUNC_EVENT, OWN_ADDRESS_RESET, 1'b0, 1'b1, 1'b0}, 1'b0, R_NONE},
      '{'{FUNC_EVENT, 8'h10, 1'b0, 1'b0, 1'b0}, 1'b0, R_NONE},
      '{'{FUNC_EVENT, 8'h20, 1'b0, 1'b0, 1'b0}, 1'b0, R_NONE},
      '{'{FUNC_EVENT, 8'h30, 1'b0, 1'b0, 1'b1}, 1'b0, R_NONE},
      // ignored func, no result
      '{'{FUNC_UNUSED, 8'hAA, 1'b1, 1'b1, 1'b1}, 1'b0, R_NONE},
      // stop right after the command byte
      '{'{FUNC_EVENT, OWN_ADDRESS_RESET, 1'b0, 1'b1, 1'b0}, 1'b0, R_NONE},
      '{'{FUNC_EVENT, 8'h00, 1'b0, 1'b0, 1'b1}, 1'b1, R_RETRY}
   };

   // dut ports
   logic                 clock;
   logic                 reset = 1'b1;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_OWN_ADDRESS;
   logic [BYTE_W-1:0]    csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [FUNC_W-1:0]    req_func = FUNC_BEGIN;
   logic [BYTE_W-1:0]    req_data_byte = '0;
   logic                 req_read_dir = 1'b0;
   logic                 req_start_seen = 1'b0;
   logic                 req_end_of_transfer = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CODE_W-1:0]    rsp_code;
   logic                 rsp_tx_valid;
   logic [BYTE_W-1:0]    rsp_tx_byte;
   logic                 rsp_request_line;
   logic                 rsp_msg_valid;
   logic [BYTE_W-1:0]    rsp_msg_byte;
   logic                 rsp_last;
   logic                 rsp_rx_overflow;

   // engine state as the bench tracks it
   logic [PHASE_W-1:0]   bus_phase;
   logic [BYTE_W-1:0]    last_rx_byte;
   logic [BYTE_W-1:0]    msg_store [RX_DEPTH];
   int                   msg_count;
   logic [BYTE_W-1:0]    req_store [TX_DEPTH];
   int                   req_count;
   int                   req_index;
   logic                 req_queued;
   logic                 req_line_level;
   logic [BYTE_W-1:0]    cfg_own_address;
   logic [BYTE_W-1:0]    cfg_noop_first;
   logic [BYTE_W-1:0]    cfg_noop_second;

   bus_result_type       step_results [$];   // results of the latest item
   bus_result_type       rsp_backlog [$];    // results still owed by the engine
   bus_result_type       got_rsp;
   bus_result_type       want_rsp;
   int                   fail_count = 0;
   int                   items_sent = 0;
   int                   idle_cycles = 0;
   bit                   calm_stretch = 1'b0;

   ec_i2c_slave_transfer_engine uut (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_data_byte       (req_data_byte),
      .req_read_dir        (req_read_dir),
      .req_start_seen      (req_start_seen),
      .req_end_of_transfer (req_end_of_transfer),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_code            (rsp_code),
      .rsp_tx_valid        (rsp_tx_valid),
      .rsp_tx_byte         (rsp_tx_byte),
      .rsp_request_line    (rsp_request_line),
      .rsp_msg_valid       (rsp_msg_valid),
      .rsp_msg_byte        (rsp_msg_byte),
      .rsp_last            (rsp_last),
      .rsp_rx_overflow     (rsp_rx_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic string show_result(bus_result_type r);
      return $sformatf("code %0d tx %0b/%02h line %0b msg %0b/%02h last %0b ovf %0b",
                       r.code, r.tx_valid, r.tx_byte, r.request_line, r.msg_valid,
                       r.msg_byte, r.last, r.rx_overflow);
   endfunction

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%t  %s", $realtime, msg);
   endfunction

   // one result, request line taken from the current line level
   function automatic void add_result(logic [CODE_W-1:0] code, logic txv, logic [BYTE_W-1:0] txb,
                                      logic mv, logic [BYTE_W-1:0] mb, logic lst, logic ovf);
      step_results.push_back('{code, txv, txb, req_line_level, mv, mb, lst, ovf});
   endfunction

   // advance the engine state by one item, filling step_results
   function automatic void engine_step(bus_item_type it);
      logic [BYTE_W-1:0] rcv;
      logic [CODE_W-1:0] code;
      logic              txv;
      logic              ovf;
      logic [BYTE_W-1:0] txb;
      int                n;
      step_results.delete();
      code = CODE_NONE;
      txv = 1'b0;
      txb = '0;
      ovf = 1'b0;
      // request loading, pulls the line low
      if (it.func == FUNC_BEGIN) begin
         req_count = 0;
         req_index = 0;
         req_queued = 1'b1;
         req_line_level = 1'b0;
         add_result(CODE_NONE, 1'b0, '0, 1'b0, '0, 1'b1, 1'b0);
         return;
      end
      if (it.func == FUNC_APPEND) begin
         // bytes past a full request store are dropped silently
         if (req_count < TX_DEPTH) begin
            req_store[req_count] = it.data;
            req_count++;
         end
         add_result(CODE_NONE, 1'b0, '0, 1'b0, '0, 1'b1, 1'b0);
         return;
      end
      if (it.func != FUNC_EVENT) return;

      // read direction reuses the last written byte
      if (!it.read_dir) last_rx_byte = it.data;
      rcv = last_rx_byte;

      // write start restarts the phase machine
      if (it.start_seen && !it.read_dir && !it.stop) begin
         bus_phase = PH_BEGIN;
         msg_count = 0;
         req_index = 0;
      end

      case (bus_phase)
         PH_BEGIN: begin
            msg_count = 0;
            req_index = 0;
            if (rcv != cfg_own_address) begin
               add_result(CODE_BAD_ADDR, 1'b0, '0, 1'b0, '0, 1'b1, 1'b0);
               return;
            end
            bus_phase = PH_CMD;
         end
         PH_CMD: begin
            if (msg_count < RX_DEPTH) begin
               msg_store[msg_count] = rcv;
               msg_count++;
            end
            bus_phase = PH_SUBCMD;
         end
         PH_SUBCMD: begin
            if (it.start_seen && it.read_dir && !it.stop) begin
               // repeated start for a read
               if (msg_store[0] != READ_COMMAND) begin
                  bus_phase = PH_BEGIN;
                  add_result(CODE_WRONG_CMD, 1'b0, '0, 1'b0, '0, 1'b1, 1'b0);
                  return;
               end
               bus_phase = PH_WRITE;
               if (!req_queued) begin
                  req_store[0] = cfg_noop_first;
                  req_store[1] = cfg_noop_second;
                  req_count = NOOP_LEN;
                  req_index = 0;
                  req_queued = 1'b1;
               end
               txv = 1'b1;
               txb = BYTE_W'(req_count);
               req_line_level = 1'b1;
            end else begin
               bus_phase = PH_READ;
               if (msg_count < RX_DEPTH) begin
                  msg_store[msg_count] = rcv;
                  msg_count++;
               end else begin
                  ovf = 1'b1;
               end
            end
         end
         PH_READ: begin
            if (msg_count >= RX_DEPTH) begin
               ovf = 1'b1;
            end else begin
               msg_store[msg_count] = rcv;
               msg_count++;
               if (it.stop) begin
                  // message dump, last mark on the final byte
                  n = msg_count;
                  for (int i = 0; i < n; i++)
                     add_result(CODE_READ_OK, 1'b0, '0, 1'b1, msg_store[i], i == n - 1, 1'b0);
                  msg_count = 0;
                  return;
               end
            end
         end
         PH_WRITE: begin
            if (req_index >= req_count) begin
               add_result(it.stop ? CODE_WRITE_OK : CODE_NO_DATA, 1'b0, '0, 1'b0, '0, 1'b1,
                          1'b0);
               return;
            end
            txv = 1'b1;
            txb = req_store[req_index];
            req_index++;
            if (it.stop) begin
               req_index = 0;
               req_queued = 1'b0;
               add_result(CODE_WRITE_OK, txv, txb, 1'b0, '0, 1'b1, 1'b0);
               return;
            end
         end
         default: ;
      endcase
      if (it.stop) code = CODE_RETRY;
      add_result(code, txv, txb, 1'b0, '0, 1'b1, ovf);
   endfunction

   function automatic bus_item_type make_item(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] data,
                                              logic rd, logic st, logic stop);
      return '{func, data, rd, st, stop};
   endfunction

   // one transfer on the request side, then maybe an idle gap
   task automatic send_transfer(input bus_item_type it, input bit typed = 1'b0,
                                input bus_result_type want = '0);
      req_valid <= 1'b1;
      req_func <= it.func;
      req_data_byte <= it.data;
      req_read_dir <= it.read_dir;
      req_start_seen <= it.start_seen;
      req_end_of_transfer <= it.stop;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      engine_step(it);
      if (typed) rsp_backlog.push_back(want);
      else foreach (step_results[i]) rsp_backlog.push_back(step_results[i]);
      if (it.func != FUNC_UNUSED) items_sent++;
      if (!calm_stretch && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // registers only change once the engine has nothing left to deliver
   task automatic settle();
      req_valid <= 1'b0;
      while (rsp_backlog.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(logic [BYTE_W-1:0] own, logic [BYTE_W-1:0] n0,
                                 logic [BYTE_W-1:0] n1);
      csr_write <= 1'b1;
      csr_index <= CSR_OWN_ADDRESS;
      csr_wdata <= own;
      @(posedge clock);
      cfg_own_address = own;
      csr_index <= CSR_NOOP_FIRST;
      csr_wdata <= n0;
      @(posedge clock);
      cfg_noop_first = n0;
      csr_index <= CSR_NOOP_SECOND;
      csr_wdata <= n1;
      @(posedge clock);
      cfg_noop_second = n1;
      csr_write <= 1'b0;
   endtask

   // master writes a message: address, command, body, stop
   task automatic run_write_transfer();
      int n;
      logic [BYTE_W-1:0] addr;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 40) : $urandom_range(0, 6);
      addr = ($urandom_range(0, 9) == 0) ? BYTE_W'($urandom) : cfg_own_address;
      send_transfer(make_item(FUNC_EVENT, addr, 1'b0, 1'b1, 1'b0));
      send_transfer(make_item(FUNC_EVENT, BYTE_W'($urandom), 1'b0, 1'b0, 1'b0));
      repeat (n) send_transfer(make_item(FUNC_EVENT, BYTE_W'($urandom), 1'b0, 1'b0, 1'b0));
      // stop, now and then in read direction
      send_transfer(make_item(FUNC_EVENT, BYTE_W'($urandom), $urandom_range(0, 4) == 0,
                              1'b0, 1'b1));
   endtask

   // master reads the queued request back
   task automatic run_read_transfer();
      int m;
      logic [BYTE_W-1:0] cmd;
      m = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 4);
      cmd = ($urandom_range(0, 9) == 0) ? BYTE_W'($urandom) : READ_COMMAND;
      send_transfer(make_item(FUNC_EVENT, cfg_own_address, 1'b0, 1'b1, 1'b0));
      send_transfer(make_item(FUNC_EVENT, cmd, 1'b0, 1'b0, 1'b0));
      send_transfer(make_item(FUNC_EVENT, BYTE_W'($urandom), 1'b1, 1'b1, 1'b0));
      repeat (m) send_transfer(make_item(FUNC_EVENT, BYTE_W'($urandom), 1'b1, 1'b0, 1'b0));
      send_transfer(make_item(FUNC_EVENT, BYTE_W'($urandom), 1'b1, 1'b0, 1'b1));
   endtask

   // software queues a request, sometimes overfilling the store
   task automatic run_request_load();
      int k;
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 35) : $urandom_range(0, 4);
      send_transfer(make_item(FUNC_BEGIN, BYTE_W'($urandom), 1'($urandom), 1'($urandom),
                              1'($urandom)));
      repeat (k)
         send_transfer(make_item(FUNC_APPEND, BYTE_W'($urandom), 1'($urandom), 1'($urandom),
                                 1'($urandom)));
   endtask

   // broken sequences: any func, any status bits
   task automatic run_noise();
      repeat ($urandom_range(1, 4))
         send_transfer(make_item(FUNC_W'($urandom_range(0, 3)), BYTE_W'($urandom),
                                 1'($urandom), 1'($urandom), 1'($urandom)));
   endtask

   task automatic run_random_phase(int goal);
      int pick;
      while (items_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) run_write_transfer();
         else if (pick < 65) run_read_transfer();
         else if (pick < 85) run_request_load();
         else run_noise();
      end
   endtask

   // result side backpressure, off during the calm stretch
   always @(posedge clock)
      rsp_stall <= !calm_stretch && ($urandom_range(0, 99) < 13);

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_rsp = '{rsp_code, rsp_tx_valid, rsp_tx_byte, rsp_request_line, rsp_msg_valid,
                     rsp_msg_byte, rsp_last, rsp_rx_overflow};
         if (rsp_backlog.size() == 0) begin
            note_failure($sformatf("unexpected result: %s", show_result(got_rsp)));
         end else begin
            want_rsp = rsp_backlog.pop_front();
            if (got_rsp.code !== want_rsp.code || got_rsp.tx_valid !== want_rsp.tx_valid ||
                got_rsp.tx_byte !== want_rsp.tx_byte ||
                got_rsp.request_line !== want_rsp.request_line ||
                got_rsp.msg_valid !== want_rsp.msg_valid ||
                got_rsp.msg_byte !== want_rsp.msg_byte || got_rsp.last !== want_rsp.last ||
                got_rsp.rx_overflow !== want_rsp.rx_overflow)
               note_failure($sformatf("mismatch: expected %s, got %s",
                                      show_result(want_rsp), show_result(got_rsp)));
         end
      end
   end

   // hang detection: no transfer on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      // reset state of the tracked engine
      bus_phase = PH_BEGIN;
      last_rx_byte = '0;
      msg_count = 0;
      req_count = 0;
      req_index = 0;
      req_queued = 1'b0;
      req_line_level = 1'b1;
      cfg_own_address = OWN_ADDRESS_RESET;
      cfg_noop_first = '0;
      cfg_noop_second = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows under reset settings
      for (int r = 0; r < DIRECTED_LEN; r++)
         send_transfer(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

      // random traffic in three register settings, extremes first
      settle();
      write_settings(8'h00, 8'hFF, 8'hFF);
      run_random_phase(ITEM_GOAL / 3);

      settle();
      write_settings(8'hFF, 8'h00, 8'h01);
      calm_stretch = 1'b1;
      run_random_phase(2 * ITEM_GOAL / 3);
      calm_stretch = 1'b0;

      settle();
      write_settings(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
      run_random_phase(ITEM_GOAL);

      // drain
      req_valid <= 1'b0;
      while (rsp_backlog.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rsp_backlog.size() != 0)
         note_failure($sformatf("%0d results never arrived", rsp_backlog.size()));

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
